// ===== rtl/wlc_pkg.sv =====
// wake light clock package: request, result and register types, codes and constants
// used by the queue front, the sequencer and the top level; depends on nothing
`timescale 1ns / 1ps

package wlc_pkg;

  localparam int unsigned TodW = 17;  // seconds-of-day width
  localparam int unsigned HourW = 5;
  localparam int unsigned MinW = 6;
  localparam int unsigned SecW = 6;
  localparam int unsigned DayW = 3;
  localparam int unsigned StepsW = 4;
  localparam int unsigned CfgIdxW = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_WEEKDAY_START = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_WEEKDAY_WAKE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WEEKDAY_OFF = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WEEKEND_START = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WEEKEND_WAKE = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_WEEKEND_OFF = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_RAMP_STEPS = 3'd6;

  // register reset values
  localparam logic [TodW-1:0] RST_START = 17'd21600;
  localparam logic [TodW-1:0] RST_WAKE = 17'd24300;
  localparam logic [TodW-1:0] RST_OFF = 17'd26100;
  localparam logic [StepsW-1:0] RST_STEPS = 4'd15;

  // time reset values
  localparam logic [SecW-1:0] RST_SECOND = 6'd30;
  localparam logic [MinW-1:0] RST_MINUTE = 6'd32;
  localparam logic [HourW-1:0] RST_HOUR = 5'd22;
  localparam logic [DayW-1:0] RST_DAY = 3'd3;

  localparam logic [HourW-1:0] HOUR_MAX = 5'd23;
  localparam logic [MinW-1:0] MINUTE_MAX = 6'd59;
  localparam logic [SecW-1:0] SECOND_MAX = 6'd59;
  localparam logic [DayW-1:0] DAY_SUNDAY = 3'd0;
  localparam logic [DayW-1:0] DAY_SATURDAY = 3'd6;

  localparam logic [TodW-1:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [TodW-1:0] SEC_PER_MIN = 17'd60;

  // led patterns
  localparam logic [7:0] LED_A_RESET = 8'h80;
  localparam logic [5:0] LED_C_RESET = 6'h3F;
  localparam logic [7:0] BLINK_A_ON = 8'hAA;
  localparam logic [5:0] BLINK_C_ON = 6'h15;
  localparam logic [7:0] BLINK_A_OFF = 8'h55;
  localparam logic [5:0] BLINK_C_OFF = 6'h2A;

  typedef struct packed {
    logic [TodW-1:0] start;
    logic [TodW-1:0] wake;
    logic [TodW-1:0] off;
  } sched_t;

  typedef struct packed {
    sched_t weekday;
    sched_t weekend;
    logic [StepsW-1:0] ramp_steps;
  } cfg_t;

  // request after classification, set values already clamped
  typedef struct packed {
    logic is_set;
    logic [HourW-1:0] hour;
    logic [MinW-1:0] minute;
    logic [SecW-1:0] second;
    logic [DayW-1:0] day;
  } req_t;

  typedef struct packed {
    logic [7:0] led_a;
    logic [5:0] led_c;
    logic led_d;
    logic [HourW-1:0] hour;
    logic [MinW-1:0] minute;
    logic [SecW-1:0] second;
    logic [DayW-1:0] day;
  } result_t;

endpackage

// ===== rtl/wlc_front.sv =====
// request front: clamps set-time values, classifies requests and queues them
// depends on wlc_pkg
`timescale 1ns / 1ps

module wlc_front #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic               req_type_i,
  input  logic [4:0]         set_hour_i,
  input  logic [5:0]         set_minute_i,
  input  logic [5:0]         set_second_i,
  input  logic [2:0]         set_day_i,
  output logic               req_valid_o,
  output wlc_pkg::req_t      req_o,
  input  logic               req_pop_i
);
  import wlc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  req_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;
  req_t            req_in;

  always_comb begin
    req_in.is_set = req_type_i;
    req_in.hour   = (set_hour_i > HOUR_MAX) ? HOUR_MAX : set_hour_i;
    req_in.minute = (set_minute_i > MINUTE_MAX) ? MINUTE_MAX : set_minute_i;
    req_in.second = (set_second_i > SECOND_MAX) ? SECOND_MAX : set_second_i;
    req_in.day    = (set_day_i > DAY_SATURDAY) ? DAY_SATURDAY : set_day_i;
  end

  assign full_o      = (count_q == CntW'(Depth));
  assign req_valid_o = (count_q != '0);
  assign req_o       = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = req_pop_i && req_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= req_in;
    end
  end

endmodule

// ===== rtl/wlc_back.sv =====
// request sequencer: keeps the time and led latches, runs the ramp divider
// and holds the result register; depends on wlc_pkg
`timescale 1ns / 1ps

module wlc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wlc_pkg::cfg_t    cfg_i,
  input  logic             req_valid_i,
  input  wlc_pkg::req_t    req_i,
  output logic             req_pop_o,
  output logic             res_valid_o,
  output wlc_pkg::result_t res_o,
  input  logic             res_pop_i
);
  import wlc_pkg::*;

  localparam int unsigned NumW = TodW + 5;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NOW   = 3'd1;
  localparam logic [2:0] S_CLASS = 3'd2;
  localparam logic [2:0] S_SAT   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_LED   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [SecW-1:0]  sec_q, sec_d;
  logic [MinW-1:0]  min_q, min_d;
  logic [HourW-1:0] hour_q, hour_d;
  logic [DayW-1:0]  day_q, day_d;
  logic             blink_q, blink_d;
  logic [7:0]       led_a_q, led_a_d;
  logic [5:0]       led_c_q, led_c_d;
  logic             led_d_q, led_d_d;

  logic [TodW-1:0]  now_q, now_d;
  sched_t           sched_q, sched_d;
  logic [NumW-1:0]  rem_q, rem_d;
  logic [TodW-1:0]  span_q, span_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [3:0]       lit_q, lit_d;

  logic             out_valid_q, out_valid_d;
  result_t          out_q, out_d;

  logic             slot_free, res_load, weekend, in_wake, in_ramp;
  logic [TodW-1:0]  span_w;
  logic [4:0]       steps_p1;
  logic [NumW-1:0]  shifted;
  logic [NumW:0]    trial;

  assign slot_free = !out_valid_q || res_pop_i;
  assign weekend   = (day_q == DAY_SUNDAY) || (day_q == DAY_SATURDAY);
  assign in_wake   = (now_q >= sched_q.wake) && (now_q <= sched_q.off);
  assign in_ramp   = (now_q >= sched_q.start) && (now_q <= sched_q.wake);
  assign span_w    = sched_q.wake - sched_q.start;
  assign steps_p1  = {1'b0, cfg_i.ramp_steps} + 5'd1;
  assign shifted   = NumW'(span_q) << cnt_q;
  assign trial     = {1'b0, rem_q} - {1'b0, shifted};

  always_comb begin
    state_d     = state_q;
    sec_d       = sec_q;
    min_d       = min_q;
    hour_d      = hour_q;
    day_d       = day_q;
    blink_d     = blink_q;
    led_a_d     = led_a_q;
    led_c_d     = led_c_q;
    led_d_d     = led_d_q;
    now_d       = now_q;
    sched_d     = sched_q;
    rem_d       = rem_q;
    span_d      = span_q;
    cnt_d       = cnt_q;
    lit_d       = lit_q;
    req_pop_o   = 1'b0;
    res_load    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i && slot_free) begin
          req_pop_o = 1'b1;
          if (req_i.is_set) begin
            hour_d   = req_i.hour;
            min_d    = req_i.minute;
            sec_d    = req_i.second;
            day_d    = req_i.day;
            res_load = 1'b1;
          end else begin
            // carry chain of the clock
            if (sec_q >= SECOND_MAX) begin
              sec_d = '0;
              if (min_q >= MINUTE_MAX) begin
                min_d = '0;
                if (hour_q >= HOUR_MAX) begin
                  hour_d = '0;
                  day_d  = (day_q >= DAY_SATURDAY) ? DAY_SUNDAY : day_q + 1'b1;
                end else begin
                  hour_d = hour_q + 1'b1;
                end
              end else begin
                min_d = min_q + 1'b1;
              end
            end else begin
              sec_d = sec_q + 1'b1;
            end
            state_d = S_NOW;
          end
        end
      end
      S_NOW: begin
        now_d = TodW'(hour_q) * SEC_PER_HOUR + TodW'(min_q) * SEC_PER_MIN + TodW'(sec_q);
        sched_d = weekend ? cfg_i.weekend : cfg_i.weekday;
        state_d = S_CLASS;
      end
      S_CLASS: begin
        if (in_wake) begin
          if (blink_q) begin
            led_a_d = BLINK_A_ON;
            led_c_d = BLINK_C_ON;
            led_d_d = 1'b0;
          end else begin
            led_a_d = BLINK_A_OFF;
            led_c_d = BLINK_C_OFF;
            led_d_d = 1'b1;
          end
          blink_d = !blink_q;
          state_d = S_OUT;
        end else if (in_ramp) begin
          if (span_w == '0) begin
            // empty ramp span saturates
            lit_d   = 4'hF;
            state_d = S_LED;
          end else begin
            rem_d   = NumW'(steps_p1) * NumW'(now_q - sched_q.start);
            span_d  = span_w;
            state_d = S_SAT;
          end
        end else if (sec_q == '0) begin
          led_d_d = 1'b1;
          state_d = S_OUT;
        end else begin
          led_a_d = '0;
          led_c_d = '0;
          led_d_d = 1'b0;
          state_d = S_OUT;
        end
      end
      S_SAT: begin
        if (rem_q >= NumW'({span_q, 4'b0000})) begin
          lit_d   = 4'hF;
          state_d = S_LED;
        end else begin
          lit_d   = '0;
          cnt_d   = 2'd3;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // one restoring quotient bit per cycle
        if (!trial[NumW]) begin
          rem_d        = trial[NumW-1:0];
          lit_d[cnt_q] = 1'b1;
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 2'd0) begin
          state_d = S_LED;
        end
      end
      S_LED: begin
        led_d_d = (lit_q != '0);
        for (int i = 0; i < 6; i++) begin
          led_c_d[i] = (5'(lit_q) >= 5'(i + 2));
        end
        for (int j = 0; j < 8; j++) begin
          led_a_d[7-j] = (5'(lit_q) >= 5'(j + 8));
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        res_load = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_load) begin
      out_valid_d  = 1'b1;
      out_d.led_a  = led_a_d;
      out_d.led_c  = led_c_d;
      out_d.led_d  = led_d_d;
      out_d.hour   = hour_d;
      out_d.minute = min_d;
      out_d.second = sec_d;
      out_d.day    = day_d;
    end else if (res_pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sec_q       <= RST_SECOND;
      min_q       <= RST_MINUTE;
      hour_q      <= RST_HOUR;
      day_q       <= RST_DAY;
      blink_q     <= 1'b0;
      led_a_q     <= LED_A_RESET;
      led_c_q     <= LED_C_RESET;
      led_d_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sec_q       <= sec_d;
      min_q       <= min_d;
      hour_q      <= hour_d;
      day_q       <= day_d;
      blink_q     <= blink_d;
      led_a_q     <= led_a_d;
      led_c_q     <= led_c_d;
      led_d_q     <= led_d_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    sched_q <= sched_d;
    rem_q   <= rem_d;
    span_q  <= span_d;
    cnt_q   <= cnt_d;
    lit_q   <= lit_d;
    out_q   <= out_d;
  end

endmodule

// ===== rtl/wake_light_clock.sv =====
// wake light clock top: register file, request queue front and sequencer back
// a set-time request shows its result in the cycle after it is taken; a tick
// goes through now and class, saturate, divide and led as needed, then out
// throughput: one set-time request per cycle while results are popped; a new
// request waits while a tick holds the single sequencer and its 4-step divider
// reset: time 22:32:30 on day 3, led latches A=0x80 C=0x3F PD7 on, queues empty
`timescale 1ns / 1ps

module wake_light_clock #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [16:0] cfg_wdata_i,
  // request side
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [4:0]  set_hour_i,
  input  logic [5:0]  set_minute_i,
  input  logic [5:0]  set_second_i,
  input  logic [2:0]  set_day_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  led_a_o,
  output logic [5:0]  led_c_o,
  output logic        led_d_o,
  output logic [4:0]  hour_now_o,
  output logic [5:0]  minute_now_o,
  output logic [5:0]  second_now_o,
  output logic [2:0]  day_now_o
);
  import wlc_pkg::*;

  cfg_t    cfg_q;
  logic    req_valid, req_pop, res_valid;
  req_t    req;
  result_t res;

  // schedule registers: the user writes only while the block is idle; no check
  // writes beyond the last index fall through the case and are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weekday.start <= RST_START;
      cfg_q.weekday.wake  <= RST_WAKE;
      cfg_q.weekday.off   <= RST_OFF;
      cfg_q.weekend.start <= RST_START;
      cfg_q.weekend.wake  <= RST_WAKE;
      cfg_q.weekend.off   <= RST_OFF;
      cfg_q.ramp_steps    <= RST_STEPS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WEEKDAY_START: cfg_q.weekday.start <= cfg_wdata_i;
        CFG_WEEKDAY_WAKE:  cfg_q.weekday.wake  <= cfg_wdata_i;
        CFG_WEEKDAY_OFF:   cfg_q.weekday.off   <= cfg_wdata_i;
        CFG_WEEKEND_START: cfg_q.weekend.start <= cfg_wdata_i;
        CFG_WEEKEND_WAKE:  cfg_q.weekend.wake  <= cfg_wdata_i;
        CFG_WEEKEND_OFF:   cfg_q.weekend.off   <= cfg_wdata_i;
        CFG_RAMP_STEPS:    cfg_q.ramp_steps    <= cfg_wdata_i[StepsW-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: takes requests while the sequencer is busy with an earlier one
  wlc_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .req_type_i   (req_type_i),
    .set_hour_i   (set_hour_i),
    .set_minute_i (set_minute_i),
    .set_second_i (set_second_i),
    .set_day_i    (set_day_i),
    .req_valid_o  (req_valid),
    .req_o        (req),
    .req_pop_i    (req_pop)
  );

  // back: clock counters, led choice and the result register
  wlc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  // result ports straight from the result register
  assign empty        = !res_valid;
  assign led_a_o      = res.led_a;
  assign led_c_o      = res.led_c;
  assign led_d_o      = res.led_d;
  assign hour_now_o   = res.hour;
  assign minute_now_o = res.minute;
  assign second_now_o = res.second;
  assign day_now_o    = res.day;

endmodule

// ===== tb/sv/wlc_tb_pkg.sv =====
// testbench-side codes for the wake light clock: request kinds and spare register index
// shared by the checker and the testbench top; depends on wlc_pkg for widths
`timescale 1ns / 1ps

package wlc_tb_pkg;

  // request kind carried on req_type
  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_SET  = 1'b1
  } req_kind_e;

  // index past the register list, writes there are dropped
  localparam logic [wlc_pkg::CfgIdxW-1:0] CFG_UNUSED = 3'd7;

  // last second of a day
  localparam int unsigned TodLast = 86399;

endpackage

// ===== tb/sv/wlc_clock_checker.sv =====
// clock and led predictor for the wake light clock, compares every popped result
// watches the register port and both queue sides; depends on wlc_pkg and wlc_tb_pkg
`timescale 1ns / 1ps

module wlc_clock_checker
  import wlc_pkg::*;
  import wlc_tb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [16:0]       cfg_wdata_i,
  input  logic              push_i,
  input  logic              full_i,
  input  logic              req_type_i,
  input  logic [4:0]        set_hour_i,
  input  logic [5:0]        set_minute_i,
  input  logic [5:0]        set_second_i,
  input  logic [2:0]        set_day_i,
  input  logic              pop_i,
  input  logic              empty_i,
  input  logic [7:0]        led_a_i,
  input  logic [5:0]        led_c_i,
  input  logic              led_d_i,
  input  logic [4:0]        hour_now_i,
  input  logic [5:0]        minute_now_i,
  input  logic [5:0]        second_now_i,
  input  logic [2:0]        day_now_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o
);

  localparam int unsigned LitMax = 15;
  localparam int unsigned PortCPins = 6;

  cfg_t            sched_cfg;
  logic [SecW-1:0]  tod_sec;
  logic [MinW-1:0]  tod_min;
  logic [HourW-1:0] tod_hour;
  logic [DayW-1:0]  tod_day;
  logic             blink_q;
  logic [7:0]       led_a_q;
  logic [5:0]       led_c_q;
  logic             led_d_q;

  result_t     expected_q[$];
  int unsigned mismatches = 0;

  function automatic void reset_model();
    sched_cfg.weekday = '{start: RST_START, wake: RST_WAKE, off: RST_OFF};
    sched_cfg.weekend = '{start: RST_START, wake: RST_WAKE, off: RST_OFF};
    sched_cfg.ramp_steps = RST_STEPS;
    tod_sec = RST_SECOND;
    tod_min = RST_MINUTE;
    tod_hour = RST_HOUR;
    tod_day = RST_DAY;
    blink_q = 1'b0;
    led_a_q = LED_A_RESET;
    led_c_q = LED_C_RESET;
    led_d_q = 1'b1;
  endfunction

  function automatic void write_register(logic [2:0] idx, logic [16:0] value);
    case (idx)
      CFG_WEEKDAY_START: sched_cfg.weekday.start = value;
      CFG_WEEKDAY_WAKE:  sched_cfg.weekday.wake = value;
      CFG_WEEKDAY_OFF:   sched_cfg.weekday.off = value;
      CFG_WEEKEND_START: sched_cfg.weekend.start = value;
      CFG_WEEKEND_WAKE:  sched_cfg.weekend.wake = value;
      CFG_WEEKEND_OFF:   sched_cfg.weekend.off = value;
      CFG_RAMP_STEPS:    sched_cfg.ramp_steps = value[StepsW-1:0];
      default: ;
    endcase
  endfunction

  // one request: either load the time or advance a second and pick the leds
  function automatic result_t predict_step(req_kind_e kind, logic [4:0] hour,
                                           logic [5:0] minute, logic [5:0] second,
                                           logic [2:0] day);
    sched_t      sc;
    int unsigned now;
    int unsigned span;
    int unsigned lit;
    int unsigned c_bits;
    int unsigned a_bits;
    if (kind == REQ_SET) begin
      tod_hour = (hour > HOUR_MAX) ? HOUR_MAX : hour;
      tod_min = (minute > MINUTE_MAX) ? MINUTE_MAX : minute;
      tod_sec = (second > SECOND_MAX) ? SECOND_MAX : second;
      tod_day = (day > DAY_SATURDAY) ? DAY_SATURDAY : day;
    end else begin
      if (tod_sec >= SECOND_MAX) begin
        tod_sec = '0;
        if (tod_min >= MINUTE_MAX) begin
          tod_min = '0;
          if (tod_hour >= HOUR_MAX) begin
            tod_hour = '0;
            tod_day = (tod_day >= DAY_SATURDAY) ? DAY_SUNDAY : tod_day + 1'b1;
          end else begin
            tod_hour = tod_hour + 1'b1;
          end
        end else begin
          tod_min = tod_min + 1'b1;
        end
      end else begin
        tod_sec = tod_sec + 1'b1;
      end

      now = tod_hour * SEC_PER_HOUR + tod_min * SEC_PER_MIN + tod_sec;
      sc = (tod_day == DAY_SUNDAY || tod_day == DAY_SATURDAY) ? sched_cfg.weekend
                                                               : sched_cfg.weekday;
      if (now >= sc.wake && now <= sc.off) begin
        led_a_q = blink_q ? BLINK_A_ON : BLINK_A_OFF;
        led_c_q = blink_q ? BLINK_C_ON : BLINK_C_OFF;
        led_d_q = !blink_q;
        blink_q = !blink_q;
      end else if (now >= sc.start && now <= sc.wake) begin
        span = sc.wake - sc.start;
        if (span == 0) begin
          lit = LitMax;
        end else begin
          lit = (sched_cfg.ramp_steps + 1) * (now - sc.start) / span;
          if (lit > LitMax) lit = LitMax;
        end
        led_d_q = (lit > 0);
        c_bits = (lit > 1) ? lit - 1 : 0;
        if (c_bits > PortCPins) c_bits = PortCPins;
        led_c_q = 6'((32'd1 << c_bits) - 1);
        a_bits = (lit > 7) ? lit - 7 : 0;
        led_a_q = 8'(16'hFF00 >> a_bits);
      end else if (tod_sec == '0) begin
        led_d_q = 1'b1;
      end else begin
        led_a_q = '0;
        led_c_q = '0;
        led_d_q = 1'b0;
      end
    end
    return '{led_a: led_a_q, led_c: led_c_q, led_d: led_d_q, hour: tod_hour,
             minute: tod_min, second: tod_sec, day: tod_day};
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      reset_model();
      expected_q.delete();
    end else begin
      if (cfg_we_i) write_register(cfg_idx_i, cfg_wdata_i);
      if (pop_i && !empty_i) begin
        seen = '{led_a: led_a_i, led_c: led_c_i, led_d: led_d_i, hour: hour_now_i,
                 minute: minute_now_i, second: second_now_i, day: day_now_i};
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, expected none, got %h", $time, seen);
        end else begin
          want = expected_q.pop_front();
          compare_field("led_a", want.led_a, seen.led_a);
          compare_field("led_c", want.led_c, seen.led_c);
          compare_field("led_d", want.led_d, seen.led_d);
          compare_field("hour_now", want.hour, seen.hour);
          compare_field("minute_now", want.minute, seen.minute);
          compare_field("second_now", want.second, seen.second);
          compare_field("day_now", want.day, seen.day);
        end
      end
      if (push_i && !full_i) begin
        expected_q.push_back(predict_step(req_kind_e'(req_type_i), set_hour_i,
                                          set_minute_i, set_second_i, set_day_i));
      end
    end
    pending_o = expected_q.size();
    errors_o = mismatches;
  end

endmodule

// ===== tb/sv/wake_light_clock_tb.sv =====
// testbench top for the wake light clock: clock, reset, request and pop drivers
// instantiates the block and wlc_clock_checker; depends on wlc_pkg and wlc_tb_pkg
`timescale 1ns / 1ps

module wake_light_clock_tb;
  import wlc_pkg::*;
  import wlc_tb_pkg::*;

  // cycles with no request, result or register write before we give up
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned Phases = 8;
  localparam int unsigned PhaseItems = 250;
  localparam int unsigned DrainCycles = 20;

  // every input of the block starts at a known value
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [16:0] cfg_wdata = '0;
  logic        push = 1'b0;
  logic        full;
  logic        req_type = REQ_TICK;
  logic [4:0]  set_hour = '0;
  logic [5:0]  set_minute = '0;
  logic [5:0]  set_second = '0;
  logic [2:0]  set_day = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  led_a;
  logic [5:0]  led_c;
  logic        led_d;
  logic [4:0]  hour_now;
  logic [5:0]  minute_now;
  logic [5:0]  second_now;
  logic [2:0]  day_now;

  int unsigned errors;
  int unsigned pending;

  // stimulus bookkeeping
  int unsigned items_sent = 0;
  bit          tx_idling = 1'b1;
  bit          rx_idling = 1'b1;
  int unsigned pop_hold = 0;
  int unsigned quiet_cycles = 0;

  // copy of the schedule as programmed, used only to aim the time jumps
  cfg_t sched_plan = '{weekday: '{start: RST_START, wake: RST_WAKE, off: RST_OFF},
                       weekend: '{start: RST_START, wake: RST_WAKE, off: RST_OFF},
                       ramp_steps: RST_STEPS};

  wake_light_clock DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .push         (push),
    .full         (full),
    .req_type_i   (req_type),
    .set_hour_i   (set_hour),
    .set_minute_i (set_minute),
    .set_second_i (set_second),
    .set_day_i    (set_day),
    .empty        (empty),
    .pop          (pop),
    .led_a_o      (led_a),
    .led_c_o      (led_c),
    .led_d_o      (led_d),
    .hour_now_o   (hour_now),
    .minute_now_o (minute_now),
    .second_now_o (second_now),
    .day_now_o    (day_now)
  );

  wlc_clock_checker clock_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .push_i       (push),
    .full_i       (full),
    .req_type_i   (req_type),
    .set_hour_i   (set_hour),
    .set_minute_i (set_minute),
    .set_second_i (set_second),
    .set_day_i    (set_day),
    .pop_i        (pop),
    .empty_i      (empty),
    .led_a_i      (led_a),
    .led_c_i      (led_c),
    .led_d_i      (led_d),
    .hour_now_i   (hour_now),
    .minute_now_i (minute_now),
    .second_now_i (second_now),
    .day_now_i    (day_now),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // 100 MHz
  initial begin
    forever #5 clk = ~clk;
  end

  // result side: pop stays high except for random stalls while rx_idling is set
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      pop_hold <= 0;
    end else if (pop_hold != 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop <= 1'b1;
      if (rx_idling && $urandom_range(0, 5) == 0) pop_hold <= $urandom_range(1, 4);
    end
  end

  // watchdog: any handshake or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t ns: no progress for %0d cycles", $time, QuietLimit);
        $display("wake_light_clock regression: fail");
        $finish;
      end
    end
  end

  // raise push with the request fields and hold them until the block takes them;
  // push is left high so a back-to-back request needs no second assignment
  task automatic send_request(req_kind_e kind, logic [4:0] hour, logic [5:0] minute,
                              logic [5:0] second, logic [2:0] day);
    push <= 1'b1;
    req_type <= kind;
    set_hour <= hour;
    set_minute <= minute;
    set_second <= second;
    set_day <= day;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  // set fields are don't-care on a tick, so they carry noise
  task automatic tick();
    send_request(REQ_TICK, 5'($urandom), 6'($urandom), 6'($urandom), 3'($urandom));
  endtask

  task automatic set_clock(int unsigned tod, logic [2:0] day);
    send_request(REQ_SET, 5'(tod / SEC_PER_HOUR), 6'((tod / SEC_PER_MIN) % 60),
                 6'(tod % SEC_PER_MIN), day);
  endtask

  task automatic sender_gap(int unsigned cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (tx_idling && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 4));
  endtask

  // hold off the sender until every request has come back out;
  // the extra edge lets the checker log a request taken on the last edge
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // all seven registers plus a write past the list that must be dropped
  task automatic program_schedule(logic [16:0] wd_start, logic [16:0] wd_wake,
                                  logic [16:0] wd_off, logic [16:0] we_start,
                                  logic [16:0] we_wake, logic [16:0] we_off,
                                  logic [16:0] steps);
    drain();
    write_reg(CFG_WEEKDAY_START, wd_start);
    write_reg(CFG_WEEKDAY_WAKE, wd_wake);
    write_reg(CFG_WEEKDAY_OFF, wd_off);
    write_reg(CFG_UNUSED, 17'($urandom));
    write_reg(CFG_WEEKEND_START, we_start);
    write_reg(CFG_WEEKEND_WAKE, we_wake);
    write_reg(CFG_WEEKEND_OFF, we_off);
    write_reg(CFG_RAMP_STEPS, steps);
    cfg_we <= 1'b0;
    sched_plan.weekday = '{start: wd_start, wake: wd_wake, off: wd_off};
    sched_plan.weekend = '{start: we_start, wake: we_wake, off: we_off};
    sched_plan.ramp_steps = steps[StepsW-1:0];
  endtask

  // mostly short ramps so every lit level shows up within a few dozen ticks;
  // now and then a long or empty ramp, an inverted ramp or an inverted wake window
  task automatic pick_window(output logic [16:0] start, output logic [16:0] wake,
                             output logic [16:0] off);
    int unsigned ramp;
    start = 17'($urandom_range(0, TodLast));
    case ($urandom_range(0, 7))
      0:       ramp = 0;
      1:       ramp = $urandom_range(200, 5000);
      default: ramp = $urandom_range(1, 48);
    endcase
    wake = 17'(start + ramp);
    off = 17'(wake + $urandom_range(0, 20));
    if ($urandom_range(0, 7) == 0) wake = 17'(start - $urandom_range(1, 30));
    if ($urandom_range(0, 7) == 0) off = 17'(wake - $urandom_range(1, 30));
  endtask

  // one well-formed burst: jump the clock near an interesting second, then tick
  // through it; about one in ten bursts opens with a set of raw, unclamped fields
  task automatic run_sequence();
    logic [2:0]  day;
    sched_t      sc;
    int unsigned anchor;
    int unsigned back;
    day = 3'($urandom_range(0, 6));
    sc = (day == DAY_SUNDAY || day == DAY_SATURDAY) ? sched_plan.weekend
                                                    : sched_plan.weekday;
    case ($urandom_range(0, 6))
      0:       anchor = sc.start;
      1:       anchor = sc.wake;
      2:       anchor = sc.off;
      3:       anchor = TodLast;
      4:       anchor = $urandom_range(sc.start, sc.wake);
      5:       anchor = $urandom_range(0, 1439) * SEC_PER_MIN;
      default: anchor = $urandom_range(0, TodLast);
    endcase
    if (anchor > TodLast) anchor = TodLast;
    back = $urandom_range(0, 6);
    anchor = (anchor >= back) ? anchor - back : 0;

    tx_idling = ($urandom_range(0, 3) != 0) && (items_sent < (Phases - 1) * PhaseItems);
    rx_idling = tx_idling || ($urandom_range(0, 3) == 0 && items_sent < (Phases - 1) * PhaseItems);

    maybe_gap();
    if ($urandom_range(0, 9) == 0) begin
      send_request(REQ_SET, 5'($urandom), 6'($urandom), 6'($urandom), 3'($urandom));
    end else begin
      set_clock(anchor, day);
    end
    repeat ($urandom_range(2, 30)) begin
      maybe_gap();
      tick();
    end
  endtask

  initial begin
    logic [16:0] wd_s, wd_w, wd_o, we_s, we_w, we_o;
    int unsigned phase_end;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset schedule: ramp 06:00:00, wake 06:45:00, off 07:15:00
    tick();                                     // 22:32:31 outside both windows
    send_request(REQ_SET, 5'h1F, 6'h3F, 6'h3F, 3'h7);  // every field clamps, leds held
    tick();                                     // midnight, Saturday wraps to Sunday
    set_clock(TodLast, 3'd5);
    tick();                                     // Friday rolls into Saturday
    send_request(REQ_SET, '0, '0, '0, DAY_SUNDAY);
    set_clock(21598, 3'd1);
    tick();
    tick();                                     // ramp opens at second zero, nothing lit
    tick();
    set_clock(24298, 3'd2);
    tick();                                     // top of the ramp, fully lit
    tick();                                     // wake window, first pattern
    tick();                                     // second pattern
    set_clock(26099, 3'd3);
    tick();                                     // last second of the wake window
    tick();                                     // past the window, all dark
    set_clock(26159, DAY_SATURDAY);
    tick();                                     // second zero only lights PD7
    set_clock(22949, DAY_SUNDAY);
    tick();                                     // mid weekend ramp, port A starts filling

    // random part in phases, each with its own schedule; the last phase runs
    // both sides without idling
    for (int phase = 0; phase < Phases; phase++) begin
      case (phase)
        0: ;  // reset schedule
        // empty weekday ramp, weekend wake window inverted and zero steps
        1: program_schedule(17'd100, 17'd100, 17'd160, '0, 17'd20, '0, '0);
        // top of the register range, steps with every upper bit set
        2: program_schedule(17'(TodLast), 17'(TodLast), '1, '1, '1, '1, '1);
        // inverted windows
        3: program_schedule(17'd50000, 17'd40000, 17'd30000, 17'd3000, 17'd3040,
                            17'd3000, 17'd7);
        default: begin
          pick_window(wd_s, wd_w, wd_o);
          pick_window(we_s, we_w, we_o);
          program_schedule(wd_s, wd_w, wd_o, we_s, we_w, we_o, 17'($urandom));
        end
      endcase
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) run_sequence();
    end

    // wait for the last results, then watch for strays
    drain();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("wake_light_clock regression: pass");
    end else begin
      $display("wake_light_clock regression: fail");
    end
    $finish;
  end

endmodule
